@@ sv/tbsc_pkg.sv @@
// shared constants, types and helpers for the three band shelf cascade
// no dependencies
package tbsc_pkg;

	localparam int CHANNELS       = 8;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 20;
	localparam int COEF_BITS      = 25;
	localparam int NUM_SLOTS      = 19;
	localparam int SLOT_BITS      = 5;
	localparam int SLOT_POLE      = 15;
	localparam int SLOT_TRIM      = 18;
	localparam int BQ_SLOTS       = 5;
	localparam int ENERGY_BITS    = 40;
	localparam int COUNT_BITS     = 32;
	localparam int STATE_BITS     = 32;
	localparam int ACC_BITS       = 64;
	localparam int OPND_BITS      = COEF_BITS + 1;
	localparam int PROD_BITS      = OPND_BITS + STATE_BITS;
	localparam int ENTRIES        = CHANNELS * 9;
	localparam int ADDR_BITS      = $clog2(ENTRIES);
	localparam int LOCALS         = 9;
	localparam int LOC_BITS       = 4;

	localparam logic signed [OPND_BITS-1:0] ONE_Q    = OPND_BITS'(64'd1 << COEF_FRAC_BITS);
	localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

	typedef enum logic [1:0] {
		CMD_PROCESS = 2'd0,
		CMD_WRITE   = 2'd1,
		CMD_READ    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_DRAIN,
		ST_FIN,
		ST_ENERGY,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		CM_PLAIN,
		CM_NEG,
		CM_COMP,
		CM_ONE
	} coef_mode_t;

	typedef enum logic [1:0] {
		DS_LOC,
		DS_X,
		DS_CUR,
		DS_W
	} data_src_t;

	typedef struct packed {
		logic                         issue;
		logic                         first;
		logic signed [OPND_BITS-1:0]  coef;
		logic signed [STATE_BITS-1:0] data;
	} mac_ctrl_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_BITS-1:0]  raddr;
		logic                  wr_en;
		logic [ADDR_BITS-1:0]  waddr;
		logic [STATE_BITS-1:0] wdata;
	} ram_ctrl_t;

	typedef struct packed {
		kind_t                         kind;
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [ENERGY_BITS-1:0]        low_energy;
		logic [ENERGY_BITS-1:0]        mid_energy;
		logic [ENERGY_BITS-1:0]        air_energy;
		logic [COUNT_BITS-1:0]         sample_total;
	} result_t;

	// trackers sit above the delay lines: delays ch*6+i, trackers CHANNELS*6+ch*3+b
	function automatic logic [ADDR_BITS-1:0] entry_addr(input logic [2:0] ch,
			input logic [LOC_BITS-1:0] r);
		int a;
		if (r < LOC_BITS'(3)) begin
			a = CHANNELS * 6 + int'(ch) * 3 + int'(r);
		end else begin
			a = int'(ch) * 6 + int'(r) - 3;
		end
		return ADDR_BITS'(a);
	endfunction

endpackage

@@ sv/tbsc_intf.sv @@
// valid/ready channel interfaces for sample items and result items
// depends on tbsc_pkg
interface tbsc_in_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              cmd;
	logic [2:0]                              channel;
	logic signed [tbsc_pkg::SAMPLE_BITS-1:0] sample_in;
	logic [tbsc_pkg::SLOT_BITS-1:0]          coef_slot;
	logic signed [tbsc_pkg::COEF_BITS-1:0]   coef_word;
	modport source(output valid, cmd, channel, sample_in, coef_slot, coef_word, input ready);
	modport sink(input valid, cmd, channel, sample_in, coef_slot, coef_word, output ready);
endinterface

interface tbsc_out_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              kind;
	logic signed [tbsc_pkg::SAMPLE_BITS-1:0] sample_out;
	logic [tbsc_pkg::ENERGY_BITS-1:0]        low_energy;
	logic [tbsc_pkg::ENERGY_BITS-1:0]        mid_energy;
	logic [tbsc_pkg::ENERGY_BITS-1:0]        air_energy;
	logic [tbsc_pkg::COUNT_BITS-1:0]         sample_total;
	modport source(output valid, kind, sample_out, low_energy, mid_energy, air_energy,
		sample_total, input ready);
	modport sink(input valid, kind, sample_out, low_energy, mid_energy, air_energy,
		sample_total, output ready);
endinterface

@@ sv/tbsc_state_ram.sv @@
// tracker and delay-line memory, one write and one registered read port
// unwritten entries read as zero via per-entry valid bits; depends on tbsc_pkg
module tbsc_state_ram (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tbsc_pkg::ram_ctrl_t                   ctrl,
	output logic signed [tbsc_pkg::STATE_BITS-1:0] rdata
);
	import tbsc_pkg::*;

	logic [STATE_BITS-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0]    vld_q;
	logic [STATE_BITS-1:0] data_s1;
	logic                  vld_s1;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.waddr] <= ctrl.wdata;
		end
		if (ctrl.rd_en) begin
			data_s1 <= mem[ctrl.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				vld_q[ctrl.waddr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				vld_s1 <= vld_q[ctrl.raddr];
			end
		end
	end

	assign rdata = vld_s1 ? signed'(data_s1) : '0;
endmodule

@@ sv/tbsc_mac.sv @@
// shared multiply-accumulate unit with rounding and saturation
// depends on tbsc_pkg
module tbsc_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tbsc_pkg::mac_ctrl_t                    ctrl,
	output logic signed [tbsc_pkg::STATE_BITS-1:0]  res_state,
	output logic signed [tbsc_pkg::SAMPLE_BITS-1:0] res_sample
);
	import tbsc_pkg::*;

	localparam logic signed [ACC_BITS-1:0] HALF   = ACC_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_BITS-1:0] ST_MAX = ACC_BITS'((64'd1 << (STATE_BITS - 1)) - 1);
	localparam logic signed [ACC_BITS-1:0] ST_MIN = -ST_MAX - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] SM_MAX = ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_BITS-1:0] SM_MIN = -SM_MAX - ACC_BITS'(1);

	logic signed [PROD_BITS-1:0] prod_s1;
	logic                        vld_s1;
	logic                        first_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			vld_s1   <= ctrl.issue;
			first_s1 <= ctrl.first;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_BITS'(ctrl.coef) * PROD_BITS'(ctrl.data);
		if (vld_s1) begin
			acc_q <= first_s1 ? ACC_BITS'(prod_s1) : acc_q + ACC_BITS'(prod_s1);
		end
	end

	// round half up, back to sample lsb units
	assign rnd = (acc_q + HALF) >>> COEF_FRAC_BITS;

	always_comb begin
		if (rnd > ST_MAX) begin
			res_state = STATE_BITS'(ST_MAX);
		end else if (rnd < ST_MIN) begin
			res_state = STATE_BITS'(ST_MIN);
		end else begin
			res_state = STATE_BITS'(rnd);
		end
		if (rnd > SM_MAX) begin
			res_sample = SAMPLE_BITS'(SM_MAX);
		end else if (rnd < SM_MIN) begin
			res_sample = SAMPLE_BITS'(SM_MIN);
		end else begin
			res_sample = SAMPLE_BITS'(rnd);
		end
	end
endmodule

@@ sv/three_band_shelf_cascade_top.sv @@
// three band shelf cascade: trackers, energies, three biquads and trim per sample
// depends on tbsc_pkg, tbsc_intf, tbsc_state_ram, tbsc_mac
// sample transaction: the input stays closed from accept until the result is registered;
//   the work runs through the single shared multiplier (25 products, drain and round per sum)
//   plus nine reads and nine write-backs through the state memory
// coefficient write and energy read: result registered out of ST_DONE, input closed till then
// a result not yet taken holds the sequencer in its last cycle until the output frees
// reset: state memory reads zero at once, pass-through filters, unity trim, zero sums
module three_band_shelf_cascade_top (
	input logic       clk,
	input logic       arst_n,
	tbsc_in_if.sink   sample_chan,
	tbsc_out_if.source result_chan
);
	import tbsc_pkg::*;

	state_t                        state_q, state_d;
	logic [LOC_BITS-1:0]           cnt_q;
	logic [3:0]                    grp_q;
	logic [1:0]                    op_q;
	logic [2:0]                    ch_q;
	logic signed [STATE_BITS-1:0]  xs_q, cur_q, w_q;
	logic signed [STATE_BITS-1:0]  loc_q [LOCALS];
	logic signed [COEF_BITS-1:0]   coef_q [NUM_SLOTS];
	logic [ENERGY_BITS-1:0]        e_low_q, e_mid_q, e_air_q;
	logic [COUNT_BITS-1:0]         total_q;
	result_t                       res_q, out_q;
	result_t                       res_new;
	logic                          out_valid_q;
	logic                          rd_v_s1;
	logic [LOC_BITS-1:0]           rd_idx_s1;

	logic                          acc_in, out_free, ch_ok;
	logic [1:0]                    op_last;
	logic [2:0]                    stg_off;
	logic [1:0]                    stg;
	logic [SLOT_BITS-1:0]          coef_idx;
	logic [LOC_BITS-1:0]           loc_idx, loc_base, loc_rd_idx;
	coef_mode_t                    cmode;
	data_src_t                     dsrc;
	logic signed [OPND_BITS-1:0]   cext;
	logic signed [STATE_BITS-1:0]  loc_rd;
	mac_ctrl_t                     mac_ctrl;
	ram_ctrl_t                     ram_ctrl;
	logic signed [STATE_BITS-1:0]  ram_rdata;
	logic signed [STATE_BITS-1:0]  res_state;
	logic signed [SAMPLE_BITS-1:0] res_sample;
	logic signed [STATE_BITS:0]    d_mid, d_air;
	logic [STATE_BITS:0]           m_low, m_mid, m_air;

	function automatic logic [STATE_BITS:0] mag(input logic signed [STATE_BITS:0] v);
		return v[STATE_BITS] ? (STATE_BITS+1)'(-v) : (STATE_BITS+1)'(v);
	endfunction

	function automatic logic [ENERGY_BITS-1:0] sat_add(input logic [ENERGY_BITS-1:0] s,
			input logic [STATE_BITS:0] m);
		logic [ENERGY_BITS:0] sum;
		sum = {1'b0, s} + (ENERGY_BITS+1)'(m);
		return sum[ENERGY_BITS] ? '1 : sum[ENERGY_BITS-1:0];
	endfunction

	tbsc_state_ram u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ram_ctrl),
		.rdata (ram_rdata)
	);

	tbsc_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.res_state (res_state),
		.res_sample(res_sample)
	);

	assign sample_chan.ready = (state_q == ST_IDLE);
	assign acc_in   = sample_chan.valid && sample_chan.ready;
	assign out_free = !out_valid_q || result_chan.ready;
	assign ch_ok    = int'(sample_chan.channel) < CHANNELS;
	assign op_last  = (grp_q < 4'd3) ? 2'd1 : ((grp_q == 4'd9) ? 2'd0 : 2'd2);
	assign stg_off  = 3'(grp_q - 4'd3);
	assign stg      = stg_off[2:1];
	assign loc_base = LOC_BITS'(3 + 2 * int'(stg));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					case (sample_chan.cmd)
						CMD_PROCESS: state_d = ch_ok ? ST_READ : ST_DONE;
						CMD_WRITE, CMD_READ: state_d = ST_DONE;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:   state_d = (cnt_q == LOC_BITS'(LOCALS)) ? ST_MAC : ST_READ;
			ST_MAC:    state_d = (op_q == op_last) ? ST_DRAIN : ST_MAC;
			ST_DRAIN:  state_d = ST_FIN;
			ST_FIN: begin
				if (grp_q == 4'd2) begin
					state_d = ST_ENERGY;
				end else if (grp_q == 4'd9) begin
					state_d = ST_WRITE;
				end else begin
					state_d = ST_MAC;
				end
			end
			ST_ENERGY: state_d = ST_MAC;
			ST_WRITE:  state_d = (cnt_q == LOC_BITS'(LOCALS - 1)) ? ST_DONE : ST_WRITE;
			ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// operand selection for the current product
	always_comb begin
		coef_idx = SLOT_BITS'(SLOT_TRIM);
		loc_idx  = '0;
		cmode    = CM_PLAIN;
		dsrc     = DS_CUR;
		if (grp_q < 4'd3) begin
			coef_idx = SLOT_BITS'(SLOT_POLE + int'(grp_q));
			loc_idx  = LOC_BITS'(grp_q);
			cmode    = (op_q == 2'd0) ? CM_PLAIN : CM_COMP;
			dsrc     = (op_q == 2'd0) ? DS_LOC : DS_X;
		end else if (grp_q < 4'd9) begin
			loc_idx = (op_q == 2'd2) ? loc_base + LOC_BITS'(1) : loc_base;
			if (!stg_off[0]) begin
				coef_idx = SLOT_BITS'(BQ_SLOTS * int'(stg) + 2 + int'(op_q));
				cmode    = (op_q == 2'd0) ? CM_ONE : CM_NEG;
				dsrc     = (op_q == 2'd0) ? DS_CUR : DS_LOC;
			end else begin
				coef_idx = SLOT_BITS'(BQ_SLOTS * int'(stg) + int'(op_q));
				cmode    = CM_PLAIN;
				dsrc     = (op_q == 2'd0) ? DS_W : DS_LOC;
			end
		end
	end

	// outputs of the sequencer
	always_comb begin
		unique case (state_q)
			ST_FIN:   loc_rd_idx = loc_base;
			ST_WRITE: loc_rd_idx = cnt_q;
			default:  loc_rd_idx = loc_idx;
		endcase
		loc_rd = loc_q[loc_rd_idx];
		cext   = OPND_BITS'(coef_q[coef_idx]);

		mac_ctrl.issue = (state_q == ST_MAC);
		mac_ctrl.first = (op_q == 2'd0);
		case (cmode)
			CM_NEG:  mac_ctrl.coef = -cext;
			CM_COMP: mac_ctrl.coef = ONE_Q - cext;
			CM_ONE:  mac_ctrl.coef = ONE_Q;
			default: mac_ctrl.coef = cext;
		endcase
		case (dsrc)
			DS_LOC:  mac_ctrl.data = loc_rd;
			DS_X:    mac_ctrl.data = xs_q;
			DS_W:    mac_ctrl.data = w_q;
			default: mac_ctrl.data = cur_q;
		endcase

		ram_ctrl.rd_en = (state_q == ST_READ) && (cnt_q < LOC_BITS'(LOCALS));
		ram_ctrl.raddr = entry_addr(ch_q, cnt_q);
		ram_ctrl.wr_en = (state_q == ST_WRITE);
		ram_ctrl.waddr = entry_addr(ch_q, cnt_q);
		ram_ctrl.wdata = loc_rd;
	end

	// result skeleton for the accepted transaction
	always_comb begin
		res_new = '0;
		case (sample_chan.cmd)
			CMD_WRITE: res_new.kind = KIND_ACK;
			CMD_READ: begin
				res_new.kind         = KIND_REPORT;
				res_new.low_energy   = e_low_q;
				res_new.mid_energy   = e_mid_q;
				res_new.air_energy   = e_air_q;
				res_new.sample_total = total_q;
			end
			default: res_new.kind = KIND_SAMPLE;
		endcase
	end

	assign d_mid = (STATE_BITS+1)'(loc_q[1]) - (STATE_BITS+1)'(loc_q[0]);
	assign d_air = (STATE_BITS+1)'(xs_q) - (STATE_BITS+1)'(loc_q[2]);
	assign m_low = mag((STATE_BITS+1)'(loc_q[0]));
	assign m_mid = mag(d_mid);
	assign m_air = mag(d_air);

	// control, coefficients and energy sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			grp_q       <= '0;
			op_q        <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			e_low_q     <= '0;
			e_mid_q     <= '0;
			e_air_q     <= '0;
			total_q     <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				coef_q[i] <= (i == 0 || i == BQ_SLOTS || i == 2 * BQ_SLOTS || i == SLOT_TRIM)
					? COEF_ONE : '0;
			end
		end else begin
			state_q <= state_d;
			rd_v_s1 <= ram_ctrl.rd_en;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_chan.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					grp_q <= '0;
					op_q  <= '0;
					if (acc_in && sample_chan.cmd == CMD_WRITE
							&& int'(sample_chan.coef_slot) < NUM_SLOTS) begin
						coef_q[sample_chan.coef_slot] <= sample_chan.coef_word;
					end
					if (acc_in && sample_chan.cmd == CMD_READ) begin
						e_low_q <= '0;
						e_mid_q <= '0;
						e_air_q <= '0;
						total_q <= '0;
					end
				end
				ST_READ: cnt_q <= cnt_q + LOC_BITS'(1);
				ST_MAC:  op_q <= (op_q == op_last) ? 2'd0 : op_q + 2'd1;
				ST_FIN: begin
					if (grp_q == 4'd9) begin
						cnt_q <= '0;
					end else begin
						grp_q <= grp_q + 4'd1;
					end
				end
				ST_ENERGY: begin
					e_low_q <= sat_add(e_low_q, m_low);
					e_mid_q <= sat_add(e_mid_q, m_mid);
					e_air_q <= sat_add(e_air_q, m_air);
					if (total_q != '1) begin
						total_q <= total_q + COUNT_BITS'(1);
					end
				end
				ST_WRITE: cnt_q <= cnt_q + LOC_BITS'(1);
				default: ;
			endcase
		end
	end

	// working values and results
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q;
		if (rd_v_s1) begin
			loc_q[rd_idx_s1] <= ram_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
		if (acc_in) begin
			ch_q  <= sample_chan.channel;
			xs_q  <= STATE_BITS'(sample_chan.sample_in);
			cur_q <= STATE_BITS'(sample_chan.sample_in);
			res_q <= res_new;
		end
		if (state_q == ST_FIN) begin
			if (grp_q < 4'd3) begin
				loc_q[grp_q] <= res_state;
			end else if (grp_q == 4'd9) begin
				res_q.sample_out <= res_sample;
			end else if (!stg_off[0]) begin
				w_q <= res_state;
			end else begin
				cur_q                          <= res_state;
				loc_q[loc_base + LOC_BITS'(1)] <= loc_rd;
				loc_q[loc_base]                <= w_q;
			end
		end
	end

	assign result_chan.valid        = out_valid_q;
	assign result_chan.kind         = out_q.kind;
	assign result_chan.sample_out   = out_q.sample_out;
	assign result_chan.low_energy   = out_q.low_energy;
	assign result_chan.mid_energy   = out_q.mid_energy;
	assign result_chan.air_energy   = out_q.air_energy;
	assign result_chan.sample_total = out_q.sample_total;
endmodule

@@ sv/tbsc_checker.sv @@
// port-level checks for the three band shelf cascade
// depends on tbsc_pkg; bound to three_band_shelf_cascade_top
module tbsc_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_ready,
	input logic [1:0]                              in_cmd,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic [1:0]                              out_kind,
	input logic signed [tbsc_pkg::SAMPLE_BITS-1:0] out_sample,
	input logic [tbsc_pkg::ENERGY_BITS-1:0]        out_low,
	input logic [tbsc_pkg::COUNT_BITS-1:0]         out_total
);
	import tbsc_pkg::*;

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_sample))
		else $error("result changed while stalled");

	// a command that gives a result keeps the input closed for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_cmd == CMD_PROCESS || in_cmd == CMD_WRITE
			|| in_cmd == CMD_READ) |=> !in_ready)
		else $error("input accepted while busy");

	a_report_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_REPORT |-> out_low == '0 && out_total == '0)
		else $error("energy fields set outside a report");

	a_sample_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_SAMPLE |-> out_sample == '0)
		else $error("sample field set outside a sample result");
endmodule

bind three_band_shelf_cascade_top tbsc_checker u_tbsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_chan.valid),
	.in_ready  (sample_chan.ready),
	.in_cmd    (sample_chan.cmd),
	.out_valid (result_chan.valid),
	.out_ready (result_chan.ready),
	.out_kind  (result_chan.kind),
	.out_sample(result_chan.sample_out),
	.out_low   (result_chan.low_energy),
	.out_total (result_chan.sample_total)
);
